[sv/sawpl_pkg.sv]
`default_nettype none
package sawpl_pkg;

    // peer table size and derived widths
    localparam int MAX_PEERS = 4;
    localparam int P_W       = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int C_W       = $clog2(MAX_PEERS + 1);

    // operations
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_PKT  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // packet types
    localparam logic PT_DATA = 1'b0;
    localparam logic PT_ACK  = 1'b1;

    // actions
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_NEW    = 2'd1;
    localparam logic [1:0] ACT_RESEND = 2'd2;
    localparam logic [1:0] ACT_RESP   = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNKNOWN  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_INVALID  = 3'd3;
    localparam logic [2:0] ST_WRONGDST = 3'd4;
    localparam logic [2:0] ST_MISMATCH = 3'd5;

    // sequence ids
    localparam logic [7:0] HANDSHAKE_ID = 8'd255;
    localparam logic [7:0] LAST_SEQ     = 8'd254;
    localparam logic [7:0] FIRST_SEQ    = 8'd1;
    localparam logic [7:0] HEADER_BYTES = 8'd6;

    // register indexes
    localparam logic [1:0] REG_OWN_ID  = 2'd0;
    localparam logic [1:0] REG_MAGIC   = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    localparam logic [19:0] TIMEOUT_RST = 20'd20000;

    // divide-by-three on a 66-bit sum
    localparam int DIV_BITS = 66;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  peer_id;
        logic        pkt_type;
        logic [7:0]  seq_id;
        logic [15:0] magic_in;
        logic [7:0]  rx_len;
        logic [7:0]  dest_peer;
        logic [63:0] now_us;
        logic        has_pending;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  action;
        logic        deliver;
        logic [7:0]  out_peer;
        logic [7:0]  out_id;
        logic        handshake_done;
        logic        is_linked;
        logic [63:0] ping_avg;
        logic [2:0]  status;
    } t_out_item;

    function automatic logic [7:0] next_seq(input logic [7:0] id);
        next_seq = (id == LAST_SEQ) ? FIRST_SEQ : id + 8'd1;
    endfunction

endpackage
`default_nettype wire

[sv/stop_and_wait_peer_link_top.sv]
// Channel   | Direction | Handshake               | Payload
// request   | in        | i_in_valid / o_in_stall | i_in_data  (t_in_item)
// result    | out       | o_out_valid/ i_out_stall| o_out_data (t_out_item)
// config    | in        | APB psel/penable/pwrite | pwdata / prdata
//
// One request at a time: accept, a search of up to MAX_PEERS table entries
// (none for op 3), execute, then the result is offered.
// An ack that blends the ping average adds six passes through the adder for
// the divide-by-three, then one write-back.
// Reset is synchronous, active low; the table is flops, no clearing pass.
// A stalled result holds; no new request is taken until it has gone.
`default_nettype none
module stop_and_wait_peer_link_top (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_stall,
    input  wire sawpl_pkg::t_in_item   i_in_data,
    output logic                       o_out_valid,
    input  wire                        i_out_stall,
    output sawpl_pkg::t_out_item       o_out_data,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire  [3:0]                 paddr,
    input  wire  [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam int C_W_L = sawpl_pkg::C_W;
    localparam logic [1:0] REG_OWN_ID_L  = sawpl_pkg::REG_OWN_ID;
    localparam logic [1:0] REG_MAGIC_L   = sawpl_pkg::REG_MAGIC;
    localparam logic [1:0] REG_TIMEOUT_L = sawpl_pkg::REG_TIMEOUT;

    // last pass of the divide-by-three: remainder correction
    localparam logic [2:0] DV_LAST = 3'd5;

    logic [2:0]  r_state;
    logic [7:0]  r_own;
    logic [15:0] r_magic;
    logic [19:0] r_timeout;

    sawpl_pkg::t_in_item r_in;
    logic                         r_full;
    logic [C_W_L-1:0]             r_idx;
    logic                         r_found;
    logic [sawpl_pkg::P_W-1:0]    r_p;

    // peer table
    logic [7:0]  r_pid   [sawpl_pkg::MAX_PEERS];
    logic [sawpl_pkg::C_W-1:0] r_count;
    logic [sawpl_pkg::MAX_PEERS-1:0] r_linked;
    logic [7:0]  r_tx    [sawpl_pkg::MAX_PEERS];
    logic [7:0]  r_rx    [sawpl_pkg::MAX_PEERS];
    logic [63:0] r_last  [sawpl_pkg::MAX_PEERS];
    logic [63:0] r_first [sawpl_pkg::MAX_PEERS];
    logic [63:0] r_avg   [sawpl_pkg::MAX_PEERS];

    // result fields
    logic [1:0]  r_act;
    logic        r_dlv;
    logic [7:0]  r_oid;
    logic        r_hs;
    logic [2:0]  r_status;

    // divider: dividend, running quotient, pass counter
    logic [sawpl_pkg::DIV_BITS-1:0] r_sum;
    logic [sawpl_pkg::DIV_BITS-1:0] r_q;
    logic [2:0]  r_cnt;

    logic        accept;
    logic        cfg_wr;
    logic        hdr_bad;
    logic        dst_bad;
    logic        lk;
    logic [7:0]  tx_e;
    logic [7:0]  rx_e;
    logic [63:0] ping;
    logic [63:0] since_last;
    logic        n_lk;
    logic [7:0]  n_tx;
    logic [7:0]  n_rx;
    logic [63:0] n_last;
    logic [63:0] n_first;
    logic [63:0] n_avg;
    logic        n_div;
    logic [1:0]  n_act;
    logic        n_dlv;
    logic [7:0]  n_oid;
    logic        n_hs;
    logic [2:0]  n_status;
    logic [sawpl_pkg::DIV_BITS-1:0] dv_a;
    logic [sawpl_pkg::DIV_BITS-1:0] dv_b;
    logic [5:0]  dv_r;
    logic [9:0]  dv_m;

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;

    // register read
    always_comb begin
        case (paddr[3:2])
            REG_OWN_ID_L:  prdata = {24'd0, r_own};
            REG_MAGIC_L:   prdata = {16'd0, r_magic};
            REG_TIMEOUT_L: prdata = {12'd0, r_timeout};
            default:       prdata = 32'd0;
        endcase
    end

    // request decode against the selected entry
    always_comb begin
        lk         = r_linked[r_p];
        tx_e       = lk ? r_tx[r_p] : sawpl_pkg::FIRST_SEQ;
        rx_e       = lk ? r_rx[r_p] : sawpl_pkg::FIRST_SEQ;
        hdr_bad    = (r_in.rx_len < sawpl_pkg::HEADER_BYTES) || (r_in.magic_in != r_magic);
        dst_bad    = (r_in.dest_peer != r_own);
        ping       = r_in.now_us - r_first[r_p];
        since_last = r_in.now_us - r_last[r_p];
        n_lk       = lk;
        n_tx       = r_tx[r_p];
        n_rx       = r_rx[r_p];
        n_last     = r_last[r_p];
        n_first    = r_first[r_p];
        n_avg      = r_avg[r_p];
        n_div      = 1'b0;
        n_act      = sawpl_pkg::ACT_NONE;
        n_dlv      = 1'b0;
        n_oid      = 8'd0;
        n_hs       = 1'b0;
        n_status   = sawpl_pkg::ST_OK;
        case (r_in.op)
            sawpl_pkg::OP_ADD: begin
                n_status = r_full ? sawpl_pkg::ST_FULL : sawpl_pkg::ST_OK;
            end
            sawpl_pkg::OP_PKT: begin
                if (hdr_bad) begin
                    n_status = sawpl_pkg::ST_INVALID;
                end else if (dst_bad) begin
                    n_status = sawpl_pkg::ST_WRONGDST;
                end else if (!r_found) begin
                    n_status = sawpl_pkg::ST_UNKNOWN;
                end else begin
                    // any valid packet links the peer
                    n_lk = 1'b1;
                    n_tx = tx_e;
                    n_rx = rx_e;
                    if (r_in.seq_id == sawpl_pkg::HANDSHAKE_ID) begin
                        if (r_in.pkt_type == sawpl_pkg::PT_DATA) begin
                            n_act = sawpl_pkg::ACT_RESP;
                            n_oid = sawpl_pkg::HANDSHAKE_ID;
                        end else begin
                            n_hs = 1'b1;
                        end
                    end else if (r_in.pkt_type == sawpl_pkg::PT_DATA) begin
                        n_act = sawpl_pkg::ACT_RESP;
                        n_oid = r_in.seq_id;
                        if (rx_e == sawpl_pkg::FIRST_SEQ
                            || r_in.seq_id == sawpl_pkg::FIRST_SEQ
                            || sawpl_pkg::next_seq(rx_e) == r_in.seq_id) begin
                            n_rx  = r_in.seq_id;
                            n_dlv = 1'b1;
                        end else begin
                            n_status = sawpl_pkg::ST_MISMATCH;
                        end
                    end else if (tx_e == r_in.seq_id) begin
                        // matching ack: average, advance, maybe start new data
                        if (r_avg[r_p] == 64'd0) begin
                            n_avg = ping;
                        end else begin
                            n_div = 1'b1;
                        end
                        n_tx   = sawpl_pkg::next_seq(tx_e);
                        n_last = 64'd0;
                        if (r_in.has_pending) begin
                            n_first = r_in.now_us;
                            n_last  = r_in.now_us;
                            n_act   = sawpl_pkg::ACT_NEW;
                            n_oid   = sawpl_pkg::next_seq(tx_e);
                        end
                    end else begin
                        n_status = sawpl_pkg::ST_MISMATCH;
                    end
                end
            end
            sawpl_pkg::OP_TICK: begin
                if (!r_found) begin
                    n_status = sawpl_pkg::ST_UNKNOWN;
                end else if (lk) begin
                    if (r_last[r_p] != 64'd0) begin
                        if (since_last > {44'd0, r_timeout}) begin
                            n_last = r_in.now_us;
                            n_act  = sawpl_pkg::ACT_RESEND;
                            n_oid  = r_tx[r_p];
                        end
                    end else if (r_in.has_pending) begin
                        n_first = r_in.now_us;
                        n_last  = r_in.now_us;
                        n_act   = sawpl_pkg::ACT_NEW;
                        n_oid   = r_tx[r_p];
                    end
                end
            end
            default: begin
                n_status = sawpl_pkg::ST_INVALID;
            end
        endcase
    end

    // divide-by-three operands: shift-add reciprocal, then remainder fix-up
    // the estimate never exceeds the quotient and the remainder stays below 32,
    // so floor(11*r/32) gives the missing quotient part
    always_comb begin
        dv_r = r_sum[5:0] - (r_q[5:0] + {r_q[4:0], 1'b0});
        dv_m = {1'b0, dv_r, 3'b000} + {3'b000, dv_r, 1'b0} + {4'b0000, dv_r};
        dv_a = r_q;
        dv_b = {{(sawpl_pkg::DIV_BITS-5){1'b0}}, dv_m[9:5]};
        case (r_cnt)
            3'd0: begin
                dv_a = {2'b00, r_sum[sawpl_pkg::DIV_BITS-1:2]};
                dv_b = {4'b0000, r_sum[sawpl_pkg::DIV_BITS-1:4]};
            end
            3'd1: dv_b = {4'b0000, r_q[sawpl_pkg::DIV_BITS-1:4]};
            3'd2: dv_b = {8'd0, r_q[sawpl_pkg::DIV_BITS-1:8]};
            3'd3: dv_b = {16'd0, r_q[sawpl_pkg::DIV_BITS-1:16]};
            3'd4: dv_b = {32'd0, r_q[sawpl_pkg::DIV_BITS-1:32]};
            default: ;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own     <= 8'd0;
            r_magic   <= 16'd0;
            r_timeout <= sawpl_pkg::TIMEOUT_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_OWN_ID_L:  r_own     <= pwdata[7:0];
                REG_MAGIC_L:   r_magic   <= pwdata[15:0];
                REG_TIMEOUT_L: r_timeout <= pwdata[19:0];
                default:       ;
            endcase
        end
    end

    // sequencer and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_linked <= '0;
            r_found  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_found <= 1'b0;
                        if (i_in_data.op == sawpl_pkg::OP_ADD
                            && r_count != sawpl_pkg::C_W'(sawpl_pkg::MAX_PEERS)) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (i_in_data.op == sawpl_pkg::OP_ADD
                            || i_in_data.op == sawpl_pkg::OP_PKT
                            || i_in_data.op == sawpl_pkg::OP_TICK) begin
                            r_state <= S_SRCH;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_SRCH: begin
                    if (r_idx >= r_count) begin
                        r_state <= S_EXEC;
                    end else if (r_pid[r_idx[sawpl_pkg::P_W-1:0]] == r_in.peer_id) begin
                        r_found <= 1'b1;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_found) begin
                        r_linked[r_p] <= n_lk;
                    end
                    // a rejected header reports no peer
                    if (r_in.op == sawpl_pkg::OP_PKT && (hdr_bad || dst_bad)) begin
                        r_found <= 1'b0;
                    end
                    r_state <= n_div ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    if (r_cnt == DV_LAST) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload: request copy, search index, table entries, divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= '0;
            for (int i = 0; i < sawpl_pkg::MAX_PEERS; i++) begin
                r_tx[i]    <= 8'd0;
                r_rx[i]    <= 8'd0;
                r_last[i]  <= 64'd0;
                r_first[i] <= 64'd0;
                r_avg[i]   <= 64'd0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_in   <= i_in_data;
                        r_idx  <= '0;
                        r_full <= (r_count == sawpl_pkg::C_W'(sawpl_pkg::MAX_PEERS));
                        if (i_in_data.op == sawpl_pkg::OP_ADD
                            && r_count != sawpl_pkg::C_W'(sawpl_pkg::MAX_PEERS)) begin
                            r_pid[r_count[sawpl_pkg::P_W-1:0]] <= i_in_data.peer_id;
                        end
                    end
                end
                S_SRCH: begin
                    r_p   <= r_idx[sawpl_pkg::P_W-1:0];
                    r_idx <= r_idx + 1'b1;
                end
                S_EXEC: begin
                    r_act    <= n_act;
                    r_dlv    <= n_dlv;
                    r_oid    <= n_oid;
                    r_hs     <= n_hs;
                    r_status <= n_status;
                    if (r_found) begin
                        r_tx[r_p]    <= n_tx;
                        r_rx[r_p]    <= n_rx;
                        r_last[r_p]  <= n_last;
                        r_first[r_p] <= n_first;
                        r_avg[r_p]   <= n_avg;
                    end
                    r_sum <= {1'b0, r_avg[r_p], 1'b0} + {2'b00, ping};
                    r_cnt <= 3'd0;
                end
                S_DIV: begin
                    r_q   <= dv_a + dv_b;
                    r_cnt <= r_cnt + 3'd1;
                end
                S_WB: begin
                    r_avg[r_p] <= r_q[63:0];
                end
                default: ;
            endcase
        end
    end

    // result assembly; everything here is held while stalled
    always_comb begin
        o_out_data.action         = r_act;
        o_out_data.deliver        = r_dlv;
        o_out_data.out_peer       = r_in.peer_id;
        o_out_data.out_id         = r_oid;
        o_out_data.handshake_done = r_hs;
        o_out_data.is_linked      = r_found && r_linked[r_p];
        o_out_data.ping_avg       = r_found ? r_avg[r_p] : 64'd0;
        o_out_data.status         = r_status;
    end

`ifndef SYNTH
    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("request taken while a result is pending");
    a_result_not_immediate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_out_valid)
        else $error("result offered in the cycle after accept");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sawpl_pkg::C_W'(sawpl_pkg::MAX_PEERS))
        else $error("peer count beyond table size");
`endif

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    sawpl_pkg::t_in_item  i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    sawpl_pkg::t_out_item o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    stop_and_wait_peer_link_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // link model state
    logic [7:0]  cfg_own;
    logic [15:0] cfg_magic;
    logic [19:0] cfg_timeout;
    logic [7:0]  tbl_id   [sawpl_pkg::MAX_PEERS];
    int          tbl_count;
    logic        tbl_link [sawpl_pkg::MAX_PEERS];
    logic [7:0]  tbl_tx   [sawpl_pkg::MAX_PEERS];
    logic [7:0]  tbl_rx   [sawpl_pkg::MAX_PEERS];
    logic [63:0] tbl_last [sawpl_pkg::MAX_PEERS];
    logic [63:0] tbl_first[sawpl_pkg::MAX_PEERS];
    logic [63:0] tbl_avg  [sawpl_pkg::MAX_PEERS];

    sawpl_pkg::t_out_item expected_q[$];
    int          mismatches = 0;
    longint      cycles = 0;
    bit          idle_on = 1'b1;
    logic [63:0] now_clk = 64'd1;
    logic [7:0]  known_ids[$];

    function automatic logic [7:0] succ_id(input logic [7:0] id);
        return (id == sawpl_pkg::LAST_SEQ) ? sawpl_pkg::FIRST_SEQ : id + 8'd1;
    endfunction

    function automatic int peer_slot(input logic [7:0] id);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_id[i] == id) return i;
        return -1;
    endfunction

    function automatic void bring_up(input int p);
        if (!tbl_link[p]) begin
            tbl_tx[p] = sawpl_pkg::FIRST_SEQ;
            tbl_rx[p] = sawpl_pkg::FIRST_SEQ;
            tbl_link[p] = 1'b1;
        end
    endfunction

    // exact floor((2a+p)/3)
    function automatic logic [63:0] blend_avg(input logic [63:0] a, input logic [63:0] pg);
        logic [65:0] s;
        s = {a, 1'b0} + {2'b00, pg};
        return 64'(s / 3);
    endfunction

    function automatic void clear_table();
        tbl_count = 0;
        for (int i = 0; i < sawpl_pkg::MAX_PEERS; i++) begin
            tbl_id[i] = '0; tbl_link[i] = 0; tbl_tx[i] = 0; tbl_rx[i] = 0;
            tbl_last[i] = 0; tbl_first[i] = 0; tbl_avg[i] = 0;
        end
    endfunction

    // offer new data if nothing is outstanding and data is pending
    function automatic logic [1:0] try_new(input int p, input logic pend,
                                           input logic [63:0] now, inout logic [7:0] oid);
        if (tbl_last[p] != 0 || !pend) return sawpl_pkg::ACT_NONE;
        tbl_first[p] = now;
        tbl_last[p] = now;
        oid = tbl_tx[p];
        return sawpl_pkg::ACT_NEW;
    endfunction

    function automatic sawpl_pkg::t_out_item predict_link(input sawpl_pkg::t_in_item r);
        sawpl_pkg::t_out_item o;
        int p;
        logic [63:0] pg;
        p = -1;
        o = '0;
        o.out_peer = r.peer_id;
        o.status = sawpl_pkg::ST_OK;
        case (r.op)
            sawpl_pkg::OP_ADD: begin
                if (tbl_count >= sawpl_pkg::MAX_PEERS) begin
                    o.status = sawpl_pkg::ST_FULL;
                end else begin
                    tbl_id[tbl_count] = r.peer_id;
                    tbl_count++;
                end
                p = peer_slot(r.peer_id);
            end
            sawpl_pkg::OP_PKT: begin
                if (r.rx_len < sawpl_pkg::HEADER_BYTES || r.magic_in != cfg_magic) begin
                    o.status = sawpl_pkg::ST_INVALID;
                end else if (r.dest_peer != cfg_own) begin
                    o.status = sawpl_pkg::ST_WRONGDST;
                end else begin
                    p = peer_slot(r.peer_id);
                    if (p < 0) begin
                        o.status = sawpl_pkg::ST_UNKNOWN;
                    end else if (r.seq_id == sawpl_pkg::HANDSHAKE_ID) begin
                        bring_up(p);
                        if (r.pkt_type == sawpl_pkg::PT_DATA) begin
                            o.action = sawpl_pkg::ACT_RESP;
                            o.out_id = sawpl_pkg::HANDSHAKE_ID;
                        end else begin
                            o.handshake_done = 1'b1;
                        end
                    end else begin
                        bring_up(p);
                        if (r.pkt_type == sawpl_pkg::PT_DATA) begin
                            o.action = sawpl_pkg::ACT_RESP;
                            o.out_id = r.seq_id;
                            if (tbl_rx[p] == sawpl_pkg::FIRST_SEQ
                                || r.seq_id == sawpl_pkg::FIRST_SEQ
                                || succ_id(tbl_rx[p]) == r.seq_id) begin
                                tbl_rx[p] = r.seq_id;
                                o.deliver = 1'b1;
                            end else begin
                                o.status = sawpl_pkg::ST_MISMATCH;
                            end
                        end else if (tbl_tx[p] == r.seq_id) begin
                            pg = r.now_us - tbl_first[p];
                            tbl_avg[p] = (tbl_avg[p] == 0) ? pg : blend_avg(tbl_avg[p], pg);
                            tbl_tx[p] = succ_id(tbl_tx[p]);
                            tbl_last[p] = 0;
                            o.action = try_new(p, r.has_pending, r.now_us, o.out_id);
                        end else begin
                            o.status = sawpl_pkg::ST_MISMATCH;
                        end
                    end
                end
            end
            sawpl_pkg::OP_TICK: begin
                p = peer_slot(r.peer_id);
                if (p < 0) begin
                    o.status = sawpl_pkg::ST_UNKNOWN;
                end else if (tbl_link[p]) begin
                    if (tbl_last[p] != 0) begin
                        if (r.now_us - tbl_last[p] > 64'(cfg_timeout)) begin
                            tbl_last[p] = r.now_us;
                            o.action = sawpl_pkg::ACT_RESEND;
                            o.out_id = tbl_tx[p];
                        end
                    end else begin
                        o.action = try_new(p, r.has_pending, r.now_us, o.out_id);
                    end
                end
            end
            default: o.status = sawpl_pkg::ST_INVALID;
        endcase
        o.is_linked = (p >= 0) ? tbl_link[p] : 1'b0;
        o.ping_avg = (p >= 0) ? tbl_avg[p] : 64'd0;
        return o;
    endfunction

    // valid stays high into the next request unless an idle gap follows
    task automatic send_request(input sawpl_pkg::t_in_item r);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= r;
        do @(posedge i_clk); while (o_in_stall);
        expected_q.push_back(predict_link(r));
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            sawpl_pkg::REG_OWN_ID:  cfg_own = val[7:0];
            sawpl_pkg::REG_MAGIC:   cfg_magic = val[15:0];
            sawpl_pkg::REG_TIMEOUT: cfg_timeout = val[19:0];
            default: ;
        endcase
    endtask

    function automatic sawpl_pkg::t_in_item mk(input logic [1:0] op, input logic [7:0] pid,
                                               input logic typ, input logic [7:0] id,
                                               input logic [63:0] now, input logic pend);
        sawpl_pkg::t_in_item r;
        r.op = op; r.peer_id = pid; r.pkt_type = typ; r.seq_id = id;
        r.magic_in = cfg_magic; r.rx_len = 8'd6 + 8'($urandom_range(0, 244));
        r.dest_peer = cfg_own; r.now_us = now; r.has_pending = pend;
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        sawpl_pkg::t_out_item exp_r;
        cycles <= cycles + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out_data);
            end else begin
                exp_r = expected_q.pop_front();
                if (o_out_data !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", exp_r, o_out_data);
                end
            end
        end
    end

    // receiver back-pressure
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 15);
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // timeout watchdog
    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("tb NOT OK");
        $finish;
    end

    task automatic test_directed();
        sawpl_pkg::t_in_item r;
        write_reg(sawpl_pkg::REG_OWN_ID, 32'd7);
        write_reg(sawpl_pkg::REG_MAGIC, 32'hA55A);
        write_reg(sawpl_pkg::REG_TIMEOUT, 32'd100);
        // unknown peer, add, handshake
        send_request(mk(sawpl_pkg::OP_TICK, 8'd3, 0, 0, 64'd5, 1));
        send_request(mk(sawpl_pkg::OP_ADD, 8'd3, 0, 0, 0, 0));
        send_request(mk(sawpl_pkg::OP_ADD, 8'd254, 0, 0, 0, 0));
        send_request(mk(sawpl_pkg::OP_ADD, 8'd3, 0, 0, 0, 0));      // duplicate
        send_request(mk(sawpl_pkg::OP_ADD, 8'd0, 0, 0, 0, 0));
        send_request(mk(sawpl_pkg::OP_ADD, 8'd9, 0, 0, 0, 0));      // full
        send_request(mk(sawpl_pkg::OP_TICK, 8'd254, 0, 0, 64'd5, 1)); // unlinked tick
        send_request(mk(sawpl_pkg::OP_PKT, 8'd3, sawpl_pkg::PT_DATA,
                        sawpl_pkg::HANDSHAKE_ID, 64'd10, 0));
        send_request(mk(sawpl_pkg::OP_PKT, 8'd254, sawpl_pkg::PT_ACK,
                        sawpl_pkg::HANDSHAKE_ID, 64'd10, 0));
        // bad length, magic, dest, op 3
        r = mk(sawpl_pkg::OP_PKT, 8'd3, sawpl_pkg::PT_DATA, 8'd1, 64'd11, 0);
        r.rx_len = 8'd5;
        send_request(r);
        r = mk(sawpl_pkg::OP_PKT, 8'd3, sawpl_pkg::PT_DATA, 8'd1, 64'd11, 0);
        r.magic_in = ~cfg_magic;
        send_request(r);
        r = mk(sawpl_pkg::OP_PKT, 8'd3, sawpl_pkg::PT_DATA, 8'd1, 64'd11, 0);
        r.dest_peer = 8'd255;
        send_request(r);
        r = mk(2'd3, 8'hFF, 1, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1); r.magic_in = 16'hFFFF;
        r.rx_len = 8'd250;
        send_request(r);
        // data order, ack, resend, wrap
        send_request(mk(sawpl_pkg::OP_PKT, 8'd3, sawpl_pkg::PT_DATA, 8'd1, 64'd12, 0));
        send_request(mk(sawpl_pkg::OP_PKT, 8'd3, sawpl_pkg::PT_DATA, 8'd5, 64'd12, 0));
        send_request(mk(sawpl_pkg::OP_PKT, 8'd3, sawpl_pkg::PT_DATA, 8'd2, 64'd12, 0));
        send_request(mk(sawpl_pkg::OP_TICK, 8'd3, 0, 0, 64'd0, 1));   // send at time zero
        send_request(mk(sawpl_pkg::OP_TICK, 8'd3, 0, 0, 64'd1000, 1));
        send_request(mk(sawpl_pkg::OP_PKT, 8'd3, sawpl_pkg::PT_ACK, 8'd9, 64'd1000, 0));
        send_request(mk(sawpl_pkg::OP_TICK, 8'd3, 0, 0, 64'd2000, 1));
        send_request(mk(sawpl_pkg::OP_TICK, 8'd3, 0, 0, 64'd2100, 1));
        send_request(mk(sawpl_pkg::OP_TICK, 8'd3, 0, 0, 64'd2101, 1));
        send_request(mk(sawpl_pkg::OP_PKT, 8'd3, sawpl_pkg::PT_ACK, 8'd1, 64'd2500, 1));
        send_request(mk(sawpl_pkg::OP_PKT, 8'd3, sawpl_pkg::PT_ACK, 8'd2,
                        64'hFFFF_FFFF_FFFF_FFFF, 1));
    endtask

    // mostly well-formed traffic among the known peer ids
    task automatic test_random(input int n);
        sawpl_pkg::t_in_item r;
        logic [127:0] raw;
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            now_clk = now_clk + 64'($urandom_range(0, 3 * cfg_timeout / 2 + 2));
            r = mk(sawpl_pkg::OP_TICK, known_ids[$urandom_range(0, known_ids.size() - 1)],
                   1'($urandom), 8'($urandom), now_clk, 1'($urandom));
            if (k < 35) begin
                r.op = sawpl_pkg::OP_PKT;
                r.pkt_type = sawpl_pkg::PT_ACK;
                p_ack: begin
                    int p;
                    p = peer_slot(r.peer_id);
                    if (p >= 0 && $urandom_range(0, 4) != 0) r.seq_id = tbl_tx[p];
                end
            end else if (k < 60) begin
                r.op = sawpl_pkg::OP_PKT;
                r.pkt_type = sawpl_pkg::PT_DATA;
                p_dat: begin
                    int p;
                    p = peer_slot(r.peer_id);
                    if (p >= 0 && $urandom_range(0, 3) != 0) r.seq_id = succ_id(tbl_rx[p]);
                end
            end else if (k < 65) begin
                r.op = sawpl_pkg::OP_PKT;
                r.seq_id = sawpl_pkg::HANDSHAKE_ID;
            end else if (k < 90) begin
                r.op = sawpl_pkg::OP_TICK;
            end else begin
                raw = {$urandom, $urandom, $urandom, $urandom};
                r = raw[$bits(sawpl_pkg::t_in_item)-1:0];
                if (k < 93) r.magic_in = cfg_magic;
                if (k < 95) r.dest_peer = cfg_own;
                if (k == 99) r.op = sawpl_pkg::OP_ADD;
            end
            send_request(r);
        end
    endtask

    task automatic phase(input logic [7:0] own, input logic [15:0] mg,
                         input logic [19:0] tmo, input int n);
        write_reg(sawpl_pkg::REG_OWN_ID, {24'd0, own});
        write_reg(sawpl_pkg::REG_MAGIC, {16'd0, mg});
        write_reg(sawpl_pkg::REG_TIMEOUT, {12'd0, tmo});
        test_random(n);
    endtask

    initial begin
        cfg_own = 8'd0; cfg_magic = 16'd0; cfg_timeout = sawpl_pkg::TIMEOUT_RST;
        clear_table();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        known_ids = '{8'd3, 8'd254, 8'd0, 8'd9};
        phase(8'd0, 16'h0000, 20'd1, 350);
        phase(8'd254, 16'hFFFF, 20'd1000000 & 20'hFFFFF, 350);
        phase(8'd42, 16'h1234, 20'd500, 350);
        idle_on = 1'b0;
        phase(8'd7, 16'hBEEF, 20'd20000, 500);
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
